[design/peer_range_tracking_table_core_macros.svh]
// Assertion macros shared by the checker of the peer range tracking table.
`ifndef PEER_RANGE_TRACKING_TABLE_CORE_MACROS_SVH
`define PEER_RANGE_TRACKING_TABLE_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PRTT_ASSERT_NOW(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("prtt check failed");

// Implication from one cycle to the next, checked outside reset.
`define PRTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prtt check failed");

// Implication checked during reset as well.
`define PRTT_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("prtt check failed");

`endif

[design/prtt_pkg.sv]
// Types, codes and constants of the peer range tracking table.
package prtt_pkg;
  localparam int DEPTH  = 8;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;
  localparam int DIST_W = 20;
  localparam int KEY_W  = 56;
  localparam int LIFE_W = 16;
  localparam int DU_W   = DIST_W - 1;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_MEAS = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] EV_ADD    = 2'd0;
  localparam logic [1:0] EV_MEAS   = 2'd1;
  localparam logic [1:0] EV_EXPIRE = 2'd2;

  localparam logic [1:0] CFG_LIFETIME = 2'd0;
  localparam logic [1:0] CFG_TICK     = 2'd1;
  localparam logic [1:0] CFG_RANGE    = 2'd2;
  localparam logic [1:0] CFG_PRECISE  = 2'd3;

  localparam logic [15:0] LIFETIME_RST = 16'd10000;
  localparam logic [15:0] TICK_RST     = 16'd500;
  localparam logic [7:0]  RANGE_RST    = 8'd50;

  localparam logic [22:0] DUTY_SCALE = 23'd6553500;
  localparam logic [23:0] RECIP_100  = 24'd10737419;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [LIFE_W-1:0]        life;
    logic                     kind;
    logic signed [DIST_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic                     start;
    logic                     present;
    logic signed [DIST_W-1:0] distance;
    logic [7:0]               range;
  } led_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_LRD, S_LCMP, S_ACT, S_ARD, S_ACMP,
    S_BRD, S_BCMP, S_LGO, S_LWAIT, S_OUT
  } state_t;
endpackage

[design/prtt_led.sv]
// LED duty unit: serial reciprocal of the range, then scale and divide by one hundred.
module prtt_led
  import prtt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  led_req_t       req,
  output logic           done,
  output logic [15:0]    duty
);
  logic              busy_r;
  logic [4:0]        step_r;
  logic [DU_W-1:0]   du_r;
  logic [7:0]        r_r;
  logic [7:0]        rem_r;
  logic [15:0]       quo_r;
  logic [15:0]       sh_r;
  logic [34:0]       prod_r;
  logic [22:0]       x_r;
  logic [46:0]       y_r;
  logic [15:0]       duty_r;
  logic              done_r;
  logic [DU_W-1:0]   du_in;
  logic [8:0]        rem_t;
  logic              far;

  assign du_in = req.distance[DIST_W-1] ? '0 : req.distance[DU_W-1:0];
  assign far   = {1'b0, du_in} > DIST_W'(15'(req.range) * 15'd100);
  assign rem_t = {rem_r, sh_r[15]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (req.start) begin
        du_r  <= du_in;
        r_r   <= req.range;
        rem_r <= '0;
        quo_r <= '0;
        sh_r  <= 16'hFFFF;
        step_r <= '0;
        if (!req.present || far) begin
          duty_r <= '0;
          done_r <= 1'b1;
        end else if (req.range == 8'd0) begin
          duty_r <= 16'hFFFF;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        done_r <= step_r > 5'd18;
        if (step_r < 5'd16) begin
          sh_r <= {sh_r[14:0], 1'b0};
          if (rem_t >= {1'b0, r_r}) begin
            rem_r <= 8'(rem_t - {1'b0, r_r});
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= rem_t[7:0];
            quo_r <= {quo_r[14:0], 1'b0};
          end
        end else if (step_r == 5'd16) begin
          prod_r <= 35'(quo_r) * 35'(du_r);
        end else if (step_r == 5'd17) begin
          x_r <= DUTY_SCALE - prod_r[22:0];
        end else if (step_r == 5'd18) begin
          y_r <= 47'(x_r) * 47'(RECIP_100);
        end else begin
          duty_r <= y_r[45:30];
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign duty = duty_r;
endmodule

[design/peer_range_tracking_table_core.sv]
// Top level of the peer range tracking table: entry memory, sequencer and result register.
//
// Input words arrive on in_*; in_tuser carries the mode (add, measurement, tick).
// Result words leave on out_*; out_tuser carries the event, out_tlast marks the
// final result of an input word. Registers are to be written on cfg_* only while
// idle, which the block itself does not enforce; cfg_ready is always high.
// One input word is taken at a time. A lookup reads the entry memory one entry
// at a time, in states S_LRD and S_LCMP, before the LED computation of an add or
// measurement. A tick takes two passes over the memory, plus one LED computation
// per expired peer. A result with a closest peer in range waits in the LED unit
// for its serial reciprocal of the range; without one the reciprocal is skipped.
// Reset empties the table, clears the closest peer and loads the register
// defaults; the memory itself is not cleared. A stalled receiver holds the
// result register, and the sequencer waits before loading the next result.
module peer_range_tracking_table_core
  import prtt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // peer_address[47:0], address_type[55:48], ranging_kind[56],
  // rtt_distance_mm[76:57], best_distance_mm[96:77],
  // precise_distance_mm[116:97], precise_valid[117]
  input  logic [119:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // add_status[0], led_duty[16:1], closest_present[17],
  // closest_slot[20:18], notify_slot[23:21]
  output logic [23:0]  out_tdata,
  // event_res[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_data
);
  state_t state_r, state_nxt;

  entry_t mem [DEPTH];
  entry_t rd;
  entry_t mem_rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic [15:0] life_cfg_r, tick_cfg_r;
  logic [7:0]  range_r;
  logic        precise_r;

  logic [1:0]               mode_r;
  logic [KEY_W-1:0]         key_r;
  logic                     kind_r;
  logic signed [DIST_W-1:0] dist_r;
  logic                     fnd_r;

  logic [CNT_W-1:0] cnt_r, j_r, w_r, rmc_r;
  logic [DEPTH-1:0] meas_r, rm_r;
  logic [DEPTH-1:0]         suf_vld_r;
  logic [IDX_W-1:0]         suf_idx_r [DEPTH];
  logic signed [DIST_W-1:0] suf_dist_r [DEPTH];
  logic                     s_vld_r, p_vld_r, cl_vld_r;
  logic [IDX_W-1:0]         s_idx_r, p_idx_r, cl_idx_r;
  logic signed [DIST_W-1:0] s_dist_r, p_dist_r, cl_dist_r;

  logic [1:0]       ev_r;
  logic             st_r, last_r, ret_tick_r;
  logic [IDX_W-1:0] slot_r;

  logic        out_vld_r;
  logic [23:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;

  led_req_t    led_req;
  logic        led_done;
  logic [15:0] led_duty;

  logic [IDX_W-1:0] jx, wx;
  logic             cand, rmb, tail_rm, out_load;
  logic [DEPTH-1:0] above;
  logic [CNT_W-1:0] s_pos;
  logic signed [DIST_W-1:0] in_dist;

  assign jx = j_r[IDX_W-1:0];
  assign wx = w_r[IDX_W-1:0];
  assign rd = mem_rdata_r;

  assign cand = meas_r[jx] && rd.kind;
  assign rmb  = !(rd.life > tick_cfg_r);
  assign s_pos = {1'b0, suf_idx_r[jx]} - rmc_r - CNT_W'(1);
  assign out_load = (state_r == S_OUT) && (!out_vld_r || out_tready);

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      above[k] = (CNT_W'(k) > j_r) && (CNT_W'(k) < cnt_r);
    end
    tail_rm = |(rm_r & above);
  end

  always_comb begin
    if (!in_tdata[56]) begin
      in_dist = in_tdata[76:57];
    end else if (precise_r && in_tdata[117]) begin
      in_dist = in_tdata[116:97];
    end else begin
      in_dist = in_tdata[96:77];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_DISP;
      S_DISP: begin
        if (mode_r == MODE_ADD || mode_r == MODE_MEAS) begin
          state_nxt = S_LRD;
        end else if (mode_r == MODE_TICK && cnt_r != '0) begin
          state_nxt = S_ARD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LRD:  state_nxt = (j_r == cnt_r) ? S_ACT : S_LCMP;
      S_LCMP: state_nxt = (rd.key == key_r) ? S_ACT : S_LRD;
      S_ACT:  state_nxt = (mode_r == MODE_MEAS && !fnd_r) ? S_IDLE : S_LGO;
      S_ARD:  state_nxt = S_ACMP;
      S_ACMP: state_nxt = (j_r == '0) ? S_BRD : S_ARD;
      S_BRD:  state_nxt = (j_r == cnt_r) ? S_IDLE : S_BCMP;
      S_BCMP: state_nxt = rm_r[jx] ? S_LGO : S_BRD;
      S_LGO:  state_nxt = S_LWAIT;
      S_LWAIT: if (led_done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = ret_tick_r ? S_BRD : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wx;
    mem_raddr = jx;
    mem_wdata = rd;
    led_req.start    = 1'b0;
    led_req.present  = cl_vld_r;
    led_req.distance = cl_dist_r;
    led_req.range    = range_r;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_ACT: begin
        if (mode_r == MODE_ADD && !fnd_r && cnt_r != CNT_W'(DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[IDX_W-1:0];
          mem_wdata = '{key: key_r, life: life_cfg_r, kind: 1'b0, distance: '0};
        end else if (mode_r == MODE_MEAS && fnd_r) begin
          mem_we    = 1'b1;
          mem_waddr = jx;
          mem_wdata = '{key: key_r, life: life_cfg_r, kind: kind_r, distance: dist_r};
        end
      end
      S_BCMP: begin
        if (!rm_r[jx]) begin
          mem_we    = 1'b1;
          mem_waddr = wx;
          mem_wdata = '{key: rd.key, life: rd.life - tick_cfg_r, kind: rd.kind,
                        distance: rd.distance};
        end
      end
      S_LGO: led_req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      life_cfg_r <= LIFETIME_RST;
      tick_cfg_r <= TICK_RST;
      range_r    <= RANGE_RST;
      precise_r  <= 1'b0;
      cnt_r      <= '0;
      meas_r     <= '0;
      cl_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          CFG_LIFETIME: life_cfg_r <= cfg_data;
          CFG_TICK:     tick_cfg_r <= cfg_data;
          CFG_RANGE:    range_r    <= cfg_data[7:0];
          CFG_PRECISE:  precise_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_r  <= 1'b1;
        out_user_r <= ev_r;
        out_last_r <= last_r;
        out_data_r <= {slot_r, cl_vld_r ? cl_idx_r : IDX_W'(0), cl_vld_r, led_duty, st_r};
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r <= in_tuser;
            key_r  <= in_tdata[55:0];
            kind_r <= in_tdata[56];
            dist_r <= in_dist;
          end
        end
        S_DISP: begin
          j_r        <= (mode_r == MODE_TICK) ? cnt_r - CNT_W'(1) : '0;
          fnd_r      <= 1'b0;
          s_vld_r    <= 1'b0;
          p_vld_r    <= 1'b0;
          w_r        <= '0;
          rmc_r      <= '0;
          ret_tick_r <= (mode_r == MODE_TICK);
        end
        S_LCMP: begin
          if (rd.key == key_r) fnd_r <= 1'b1;
          else j_r <= j_r + CNT_W'(1);
        end
        S_ACT: begin
          ev_r   <= (mode_r == MODE_MEAS) ? EV_MEAS : EV_ADD;
          last_r <= 1'b1;
          if (mode_r == MODE_ADD && !fnd_r && cnt_r == CNT_W'(DEPTH)) begin
            st_r   <= 1'b1;
            slot_r <= '0;
          end else if (mode_r == MODE_ADD && !fnd_r) begin
            st_r   <= 1'b0;
            slot_r <= cnt_r[IDX_W-1:0];
            meas_r[cnt_r[IDX_W-1:0]] <= 1'b0;
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            st_r   <= 1'b0;
            slot_r <= jx;
            if (mode_r == MODE_MEAS && fnd_r) begin
              meas_r[jx] <= 1'b1;
              if (!kind_r) begin
                if (cl_idx_r == jx) cl_vld_r <= 1'b0;
              end else if (!cl_vld_r || cl_idx_r == jx || !(cl_dist_r < dist_r)) begin
                cl_vld_r  <= 1'b1;
                cl_idx_r  <= jx;
                cl_dist_r <= dist_r;
              end
            end
          end
        end
        S_ACMP: begin
          rm_r[jx]       <= rmb;
          suf_vld_r[jx]  <= s_vld_r;
          suf_idx_r[jx]  <= s_idx_r;
          suf_dist_r[jx] <= s_dist_r;
          if (cand && (!s_vld_r || rd.distance < s_dist_r)) begin
            s_vld_r  <= 1'b1;
            s_idx_r  <= jx;
            s_dist_r <= rd.distance;
          end
          j_r <= (j_r == '0) ? '0 : j_r - CNT_W'(1);
        end
        S_BRD: begin
          if (j_r == cnt_r) begin
            cnt_r <= w_r;
            for (int k = 0; k < DEPTH; k++) begin
              if (CNT_W'(k) >= w_r) meas_r[k] <= 1'b0;
            end
          end
        end
        S_BCMP: begin
          j_r <= j_r + CNT_W'(1);
          if (!rm_r[jx]) begin
            meas_r[wx] <= meas_r[jx];
            w_r <= w_r + CNT_W'(1);
            if (cand && (!p_vld_r || rd.distance <= p_dist_r)) begin
              p_vld_r  <= 1'b1;
              p_idx_r  <= wx;
              p_dist_r <= rd.distance;
            end
          end else begin
            ev_r   <= EV_EXPIRE;
            st_r   <= 1'b0;
            slot_r <= wx;
            last_r <= !tail_rm;
            rmc_r  <= rmc_r + CNT_W'(1);
            if (suf_vld_r[jx] && (!p_vld_r || suf_dist_r[jx] <= p_dist_r)) begin
              cl_vld_r  <= 1'b1;
              cl_idx_r  <= s_pos[IDX_W-1:0];
              cl_dist_r <= suf_dist_r[jx];
            end else begin
              cl_vld_r  <= p_vld_r;
              cl_idx_r  <= p_idx_r;
              cl_dist_r <= p_dist_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  prtt_led u_led (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (led_req),
    .done  (led_done),
    .duty  (led_duty)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
endmodule

[design/prtt_checker.sv]
// Port-level checker of the peer range tracking table, bound to the top level.
`include "peer_range_tracking_table_core_macros.svh"

module prtt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [23:0]  out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast,
  input logic         cfg_ready
);
  `PRTT_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)
  `PRTT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `PRTT_ASSERT_NEXT(a_hold_word, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `PRTT_ASSERT_NOW(a_cfg_ready, cfg_ready)
endmodule

bind peer_range_tracking_table_core prtt_checker u_prtt_checker (.*);

[dv/peer_range_tracking_table_core_test.sv]
// Self-checking testbench of the peer range tracking table core with its own table predictor.
module peer_range_tracking_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prtt_pkg::*;

  typedef struct {
    logic [1:0]   mode;
    logic [119:0] data;
  } in_word_t;

  typedef struct {
    logic [1:0]  ev;
    logic        status;
    logic [15:0] duty;
    logic        present;
    logic [2:0]  cslot;
    logic [2:0]  nslot;
    logic        last;
  } peer_result_t;

  localparam int NONE = DEPTH;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic [1:0]   in_tuser = MODE_ADD;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_addr = CFG_LIFETIME;
  logic [15:0]  cfg_data = '0;

  peer_range_tracking_table_core dut (.*);

  in_word_t     pending_words[$];
  peer_result_t expected_results[$];
  int           mismatches = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  bit           steady = 0;
  int           quiet_cycles = 0;

  // Predictor copy of the table and registers.
  int                  peers;
  logic [KEY_W-1:0]    tbl_key[DEPTH];
  logic [LIFE_W-1:0]   tbl_life[DEPTH];
  bit                  tbl_measured[DEPTH];
  bit                  tbl_kind[DEPTH];
  logic signed [DIST_W-1:0] tbl_dist[DEPTH];
  int                  closest;
  logic [15:0]         reg_lifetime = LIFETIME_RST;
  logic [15:0]         reg_tick = TICK_RST;
  logic [7:0]          reg_range = RANGE_RST;
  bit                  reg_precise = 0;

  logic [KEY_W-1:0] key_pool[12];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int closer_of(int a, int b);
    if (a >= NONE) return tbl_kind[b] ? b : NONE;
    if (!tbl_kind[a] && !tbl_kind[b]) return NONE;
    if (!tbl_kind[a]) return b;
    if (!tbl_kind[b]) return a;
    return (tbl_dist[a] < tbl_dist[b]) ? a : b;
  endfunction

  function automatic logic [15:0] duty_of();
    longint d;
    longint r;
    if (closest >= NONE) return 16'd0;
    d = tbl_dist[closest];
    if (d < 0) d = 0;
    r = reg_range;
    if (d > 100 * r) return 16'd0;
    if (r == 0) return 16'hFFFF;
    return 16'((6553500 - (65535 / r) * d) / 100);
  endfunction

  function automatic void push_result(logic [1:0] ev, logic status, int slot);
    peer_result_t res;
    res.ev = ev;
    res.status = status;
    res.duty = duty_of();
    res.present = closest < NONE;
    res.cslot = (closest < NONE) ? 3'(closest) : 3'd0;
    res.nslot = 3'(slot);
    res.last = 1'b0;
    expected_results.push_back(res);
  endfunction

  function automatic void predict_table(logic [1:0] mode, logic [119:0] data);
    logic [KEY_W-1:0] key;
    int found;
    int i;
    int made;
    key = data[55:0];
    found = NONE;
    made = 0;
    for (i = 0; i < peers; i++)
      if (found == NONE && tbl_key[i] == key) found = i;
    if (mode == MODE_ADD) begin
      if (found < NONE) begin
        push_result(EV_ADD, 1'b0, found);
      end else if (peers >= DEPTH) begin
        push_result(EV_ADD, 1'b1, 0);
      end else begin
        tbl_key[peers] = key;
        tbl_life[peers] = reg_lifetime;
        tbl_measured[peers] = 0;
        tbl_kind[peers] = 0;
        tbl_dist[peers] = '0;
        push_result(EV_ADD, 1'b0, peers);
        peers++;
      end
      made = 1;
    end else if (mode == MODE_MEAS) begin
      if (found < NONE) begin
        tbl_kind[found] = data[56];
        if (!data[56]) tbl_dist[found] = data[76:57];
        else if (reg_precise && data[117]) tbl_dist[found] = data[116:97];
        else tbl_dist[found] = data[96:77];
        tbl_measured[found] = 1;
        tbl_life[found] = reg_lifetime;
        closest = closer_of(closest, found);
        push_result(EV_MEAS, 1'b0, found);
        made = 1;
      end
    end else if (mode == MODE_TICK) begin
      i = 0;
      while (i < peers) begin
        if (tbl_life[i] > reg_tick) begin
          tbl_life[i] -= reg_tick;
          i++;
        end else begin
          for (int j = i; j < peers - 1; j++) begin
            tbl_key[j] = tbl_key[j+1];
            tbl_life[j] = tbl_life[j+1];
            tbl_measured[j] = tbl_measured[j+1];
            tbl_kind[j] = tbl_kind[j+1];
            tbl_dist[j] = tbl_dist[j+1];
          end
          peers--;
          tbl_measured[peers] = 0;
          closest = NONE;
          for (int j = 0; j < peers; j++)
            if (tbl_measured[j]) closest = closer_of(closest, j);
          push_result(EV_EXPIRE, 1'b0, i);
          made++;
        end
      end
    end
    if (made > 0) expected_results[$].last = 1'b1;
  endfunction

  function automatic void queue_word(logic [1:0] mode, int k, int kind,
                                     logic [19:0] rtt, logic [19:0] best,
                                     logic [19:0] prec, int pv);
    in_word_t w;
    w.mode = mode;
    w.data = {2'b00, 1'(pv), prec, best, rtt, 1'(kind), key_pool[k]};
    pending_words.push_back(w);
  endfunction

  function automatic logic [19:0] rand_dist();
    if ($urandom_range(0, 2) == 0) return 20'($urandom);
    return 20'($urandom_range(0, 30000));
  endfunction

  function automatic void queue_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 42)
        queue_word(MODE_ADD, $urandom_range(0, 11), $urandom, 20'($urandom),
                   20'($urandom), 20'($urandom), $urandom);
      else if (r < 85)
        queue_word(MODE_MEAS, $urandom_range(0, 11), $urandom, rand_dist(),
                   rand_dist(), rand_dist(), $urandom);
      else
        queue_word(MODE_TICK, $urandom_range(0, 11), $urandom, 20'($urandom),
                   20'($urandom), 20'($urandom), $urandom);
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] life, logic [15:0] tick, logic [7:0] range, bit prec);
    write_reg(CFG_LIFETIME, life);
    write_reg(CFG_TICK, tick);
    write_reg(CFG_RANGE, {8'd0, range});
    write_reg(CFG_PRECISE, {15'd0, prec});
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_LIFETIME: reg_lifetime = cfg_data;
        CFG_TICK: reg_tick = cfg_data;
        CFG_RANGE: reg_range = cfg_data[7:0];
        CFG_PRECISE: reg_precise = cfg_data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    in_word_t w;
    bit next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_table(in_tuser, in_tdata);
        next_valid = 0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_tdata <= w.data;
          in_tuser <= w.mode;
          next_valid = 1;
          in_gap <= pick_gap();
        end
      end
      in_tvalid <= next_valid;
    end
  end

  always @(posedge clk) begin
    peer_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word tdata=%h tuser=%0d", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.ev || out_tdata[0] !== want.status ||
              out_tdata[16:1] !== want.duty || out_tdata[17] !== want.present ||
              out_tdata[20:18] !== want.cslot || out_tdata[23:21] !== want.nslot ||
              out_tlast !== want.last) begin
            if (mismatches < 10)
              $display("result mismatch: expected ev=%0d st=%0d duty=%0d pres=%0d cs=%0d ns=%0d last=%0d, got ev=%0d st=%0d duty=%0d pres=%0d cs=%0d ns=%0d last=%0d",
                       want.ev, want.status, want.duty, want.present, want.cslot,
                       want.nslot, want.last, out_tuser, out_tdata[0], out_tdata[16:1],
                       out_tdata[17], out_tdata[20:18], out_tdata[23:21], out_tlast);
            mismatches++;
          end
        end
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("peer_range_tracking_table_core_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    peers = 0;
    closest = NONE;
    key_pool[0] = {8'h00, 48'h0};
    key_pool[1] = {8'hFF, 48'hFFFF_FFFF_FFFF};
    key_pool[2] = {8'hFF, 48'h0};
    key_pool[3] = {8'h00, 48'hFFFF_FFFF_FFFF};
    for (int k = 4; k < 12; k++) key_pool[k] = {8'($urandom), 16'($urandom), 32'($urandom)};
    key_pool[5][55:48] = key_pool[4][55:48] ^ 8'h01;
    key_pool[5][47:0] = key_pool[4][47:0];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part with register defaults, then a short lifetime for expiry.
    queue_word(MODE_MEAS, 0, 1, 20'd0, 20'd0, 20'd0, 0);
    queue_word(MODE_TICK, 0, 0, 20'd0, 20'd0, 20'd0, 0);
    for (int k = 0; k < 9; k++) queue_word(MODE_ADD, k, 0, '1, '1, '1, 1);
    queue_word(MODE_ADD, 3, 0, 20'd0, 20'd0, 20'd0, 0);
    queue_word(MODE_MEAS, 0, 0, 20'h80000, 20'h7FFFF, 20'h7FFFF, 1);
    queue_word(MODE_MEAS, 1, 1, 20'h7FFFF, 20'h80000, 20'h7FFFF, 1);
    queue_word(MODE_MEAS, 2, 1, 20'h0, 20'd4000, 20'd100, 1);
    queue_word(MODE_MEAS, 3, 1, 20'h0, 20'd5000, 20'h80000, 0);
    queue_word(MODE_MEAS, 4, 1, 20'h0, 20'd1, 20'd0, 1);
    queue_word(MODE_MEAS, 4, 0, 20'd7, 20'd1, 20'd0, 1);
    queue_word(MODE_MEAS, 9, 1, 20'h0, 20'd0, 20'd0, 1);
    wait_idle();
    set_regs(16'd1000, 16'd400, 8'd255, 1'b1);
    queue_word(MODE_MEAS, 5, 1, 20'd0, 20'd300, 20'd25500, 1);
    queue_word(MODE_MEAS, 6, 1, 20'd0, 20'd300, 20'd25501, 1);
    for (int t = 0; t < 3; t++) queue_word(MODE_TICK, 0, 0, '0, '0, '0, 0);
    queue_random(40);
    wait_idle();

    set_regs(16'd1, 16'd65535, 8'd1, 1'b0);
    queue_random(50);
    wait_idle();
    steady = 1;
    set_regs(16'd65535, 16'd1, 8'd255, 1'b1);
    queue_random(50);
    wait_idle();
    steady = 0;
    set_regs(16'd2500, 16'd700, 8'd120, 1'b1);
    queue_random(70);
    wait_idle();
    set_regs(16'd800, 16'd200, 8'd20, 1'b0);
    queue_random(70);
    wait_idle();
    set_regs(16'd10000, 16'd500, 8'd50, 1'b1);
    queue_random(40);
    wait_idle();

    if (mismatches == 0)
      $display("peer_range_tracking_table_core_test: PASS");
    else
      $display("peer_range_tracking_table_core_test: FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/prtt_pkg.sv
design/prtt_led.sv
design/peer_range_tracking_table_core.sv
design/prtt_checker.sv
dv/peer_range_tracking_table_core_test.sv
